// ===== sv/indexed_circular_list_manager_unit_defines.svh =====
// Assertion macros used by the port-level checker of the list manager.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef INDEXED_CIRCULAR_LIST_MANAGER_UNIT_DEFINES_SVH
`define INDEXED_CIRCULAR_LIST_MANAGER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset only
`define ICLM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset only
`define ICLM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/iclm_pkg.sv =====
// Types and constants of the indexed circular list manager.
// Used by the sequencer and the top level; depends on nothing.
package iclm_pkg;

	// Command codes
	typedef enum logic [2:0] {
		CMD_ROOT   = 3'd0,
		CMD_AFTER  = 3'd1,
		CMD_BEFORE = 3'd2,
		CMD_UNLINK = 3'd3,
		CMD_LOCATE = 3'd4,
		CMD_COUNT  = 3'd5
	} cmd_t;

	// Microprogram counter
	typedef logic [4:0] upc_t;

	// Read address source
	typedef enum logic [1:0] {
		RD_AN,
		RD_IT,
		RD_CUR
	} rd_sel_t;

	// Write address source
	typedef enum logic [1:0] {
		WA_AN,
		WA_IT,
		WA_P,
		WA_N
	} wa_sel_t;

	// Next-link write data source
	typedef enum logic [1:0] {
		ND_IT,
		ND_AN,
		ND_N
	} nd_sel_t;

	// Prev-link write data source
	typedef enum logic [1:0] {
		PD_IT,
		PD_AN,
		PD_P
	} pd_sel_t;

	// Root-link write data source
	typedef enum logic {
		RTD_IT,
		RTD_RT
	} rtd_sel_t;

	// Sequencing of the next step
	typedef enum logic [2:0] {
		BR_STEP,
		BR_JUMP,
		BR_JUMP_LONE,
		BR_WALK,
		BR_FINISH
	} br_t;

	// One control word
	typedef struct packed {
		rd_sel_t  rd_sel;
		logic     latch;
		wa_sel_t  wa_sel;
		logic     we_next;
		logic     we_prev;
		logic     we_root;
		nd_sel_t  nd_sel;
		pd_sel_t  pd_sel;
		rtd_sel_t rtd_sel;
		br_t      br;
		upc_t     target;
	} uword_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic lone;
		logic walk_end;
		logic out_free;
	} iclm_stat_t;

	// Sequencer outputs to the datapath
	typedef struct packed {
		uword_t uw;
		logic   busy;
		logic   deliver;
	} seq_ctl_t;

endpackage

// ===== sv/iclm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module iclm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/iclm_useq.sv =====
// Microcode sequencer: step counter, control store and dispatch.
// Depends on iclm_pkg.
module iclm_useq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  iclm_pkg::cmd_t         cmd,
	input  iclm_pkg::iclm_stat_t   stat,
	output iclm_pkg::seq_ctl_t     ctl
);
	import iclm_pkg::*;

	// program entry points
	localparam upc_t PC_ROOT = 5'd0;
	localparam upc_t PC_IA0  = 5'd1;
	localparam upc_t PC_IA1  = 5'd2;
	localparam upc_t PC_IA2  = 5'd3;
	localparam upc_t PC_IA3  = 5'd4;
	localparam upc_t PC_IB0  = 5'd5;
	localparam upc_t PC_IB1  = 5'd6;
	localparam upc_t PC_IB2  = 5'd7;
	localparam upc_t PC_IB3  = 5'd8;
	localparam upc_t PC_UL0  = 5'd9;
	localparam upc_t PC_UL1  = 5'd10;
	localparam upc_t PC_UL2  = 5'd11;
	localparam upc_t PC_UL3  = 5'd12;
	localparam upc_t PC_UL4  = 5'd13;
	localparam upc_t PC_WK0  = 5'd14;
	localparam upc_t PC_WK1  = 5'd15;
	localparam upc_t PC_END  = 5'd16;

	upc_t   upc_q;
	logic   busy_q;
	uword_t uw;

	// control store
	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		w.rd_sel  = RD_AN;
		w.latch   = 1'b0;
		w.wa_sel  = WA_IT;
		w.we_next = 1'b0;
		w.we_prev = 1'b0;
		w.we_root = 1'b0;
		w.nd_sel  = ND_IT;
		w.pd_sel  = PD_IT;
		w.rtd_sel = RTD_IT;
		w.br      = BR_STEP;
		w.target  = PC_END;
		case (pc)
			// make root: self-loop all three links
			PC_ROOT: begin
				w.wa_sel = WA_IT;
				w.we_next = 1'b1; w.we_prev = 1'b1; w.we_root = 1'b1;
				w.br = BR_JUMP;
			end
			// insert after anchor
			PC_IA0: w.rd_sel = RD_AN;
			PC_IA1: begin
				w.latch = 1'b1;
				w.wa_sel = WA_AN; w.we_next = 1'b1; w.nd_sel = ND_IT;
			end
			PC_IA2: begin
				w.wa_sel = WA_IT;
				w.we_next = 1'b1; w.we_prev = 1'b1; w.we_root = 1'b1;
				w.nd_sel = ND_N; w.pd_sel = PD_AN; w.rtd_sel = RTD_RT;
			end
			PC_IA3: begin
				w.wa_sel = WA_N; w.we_prev = 1'b1; w.pd_sel = PD_IT;
				w.br = BR_JUMP;
			end
			// insert before anchor
			PC_IB0: w.rd_sel = RD_AN;
			PC_IB1: begin
				w.latch = 1'b1;
				w.wa_sel = WA_AN; w.we_prev = 1'b1; w.pd_sel = PD_IT;
			end
			PC_IB2: begin
				w.wa_sel = WA_IT;
				w.we_next = 1'b1; w.we_prev = 1'b1; w.we_root = 1'b1;
				w.nd_sel = ND_AN; w.pd_sel = PD_P; w.rtd_sel = RTD_RT;
			end
			PC_IB3: begin
				w.wa_sel = WA_P; w.we_next = 1'b1; w.nd_sel = ND_IT;
				w.br = BR_JUMP;
			end
			// unlink item, skipped when it is alone
			PC_UL0: w.rd_sel = RD_IT;
			PC_UL1: begin
				w.latch = 1'b1;
				w.br = BR_JUMP_LONE;
			end
			PC_UL2: begin
				w.wa_sel = WA_IT;
				w.we_next = 1'b1; w.we_prev = 1'b1; w.we_root = 1'b1;
			end
			PC_UL3: begin
				w.wa_sel = WA_P; w.we_next = 1'b1; w.nd_sel = ND_N;
			end
			PC_UL4: begin
				w.wa_sel = WA_N; w.we_prev = 1'b1; w.pd_sel = PD_P;
				w.br = BR_JUMP;
			end
			// walk for locate and count
			PC_WK0: w.rd_sel = RD_AN;
			PC_WK1: begin
				w.rd_sel = RD_CUR;
				w.br = BR_WALK;
			end
			PC_END: w.br = BR_FINISH;
			default: w.br = BR_FINISH;
		endcase
		return w;
	endfunction

	// dispatch table
	function automatic upc_t entry_pc(input cmd_t c);
		upc_t pc;
		case (c)
			CMD_ROOT:   pc = PC_ROOT;
			CMD_AFTER:  pc = PC_IA0;
			CMD_BEFORE: pc = PC_IB0;
			CMD_UNLINK: pc = PC_UL0;
			CMD_LOCATE: pc = PC_WK0;
			CMD_COUNT:  pc = PC_WK0;
			default:    pc = PC_END;
		endcase
		return pc;
	endfunction

	// current word, quiet while idle
	always_comb begin
		uw = ucode(upc_q);
		if (!busy_q) begin
			uw.latch   = 1'b0;
			uw.we_next = 1'b0;
			uw.we_prev = 1'b0;
			uw.we_root = 1'b0;
			uw.br      = BR_STEP;
		end
		ctl.uw      = uw;
		ctl.busy    = busy_q;
		ctl.deliver = busy_q && (uw.br == BR_FINISH) && stat.out_free;
	end

	// step counter and conditional jumps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= PC_END;
			busy_q <= 1'b0;
		end else if (start) begin
			upc_q  <= entry_pc(cmd);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			case (uw.br)
				BR_STEP:      upc_q <= upc_q + upc_t'(1);
				BR_JUMP:      upc_q <= uw.target;
				BR_JUMP_LONE: upc_q <= stat.lone ? uw.target : upc_q + upc_t'(1);
				BR_WALK:      upc_q <= stat.walk_end ? uw.target : upc_q;
				BR_FINISH: begin
					if (stat.out_free) begin
						busy_q <= 1'b0;
					end
				end
				default:      upc_q <= PC_END;
			endcase
		end
	end

endmodule

// ===== sv/indexed_circular_list_manager_unit.sv =====
// Indexed circular list manager: microcoded control over three link RAMs.
// Commands: make root, insert after, insert before, unlink (cut short for a lone
// node), and locate and count, which follow next links from the anchor.
// One item at a time: the next can be taken in the cycle after the result is
// registered (it waits for a free output); each walk step is one next-link read.
// Reset clears the sequencer and output valid; link RAMs are not cleared.
module indexed_circular_list_manager_unit #(
	parameter int POOL_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] cmd,
	input  logic [7:0] anchor_index,
	input  logic [7:0] item_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result_value
);
	import iclm_pkg::*;

	localparam int AW = $clog2(POOL_DEPTH);
	localparam int CW = $clog2(POOL_DEPTH + 1);

	logic          accept;
	cmd_t          cmd_q;
	logic [AW-1:0] an_q, it_q, rt_q, p_q, n_q;
	logic [CW-1:0] steps_q;
	logic [7:0]    res_q;
	logic          out_valid_q;
	logic [7:0]    result_q;

	logic [AW-1:0] next_rd, prev_rd, root_rd;
	logic [AW-1:0] raddr, waddr, nd, pd, rtd;
	logic [7:0]    walk_res;
	logic [CW+7:0] steps_w;

	iclm_stat_t stat;
	seq_ctl_t   ctl;

	// reduce an 8-bit index modulo the pool depth by restoring subtraction
	function automatic logic [AW-1:0] pool_idx(input logic [7:0] v);
		logic [24:0]   r;
		logic [AW+7:0] w;
		r = {17'd0, v};
		for (int k = 7; k >= 0; k--) begin
			if (r >= (25'(POOL_DEPTH) << k)) begin
				r = r - (25'(POOL_DEPTH) << k);
			end
		end
		w = {{AW{1'b0}}, r[7:0]};
		return w[AW-1:0];
	endfunction

	function automatic logic [7:0] to_byte(input logic [AW-1:0] v);
		logic [AW+7:0] w;
		w = {8'd0, v};
		return w[7:0];
	endfunction

	assign in_ready = !ctl.busy;
	assign accept   = in_valid && in_ready;

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			an_q  <= pool_idx(anchor_index);
			it_q  <= pool_idx(item_index);
		end
	end

	// neighbor latch
	always_ff @(posedge clk) begin
		if (ctl.uw.latch) begin
			rt_q <= root_rd;
			p_q  <= prev_rd;
			n_q  <= next_rd;
		end
	end

	// address and data selection
	always_comb begin
		case (ctl.uw.rd_sel)
			RD_AN:   raddr = an_q;
			RD_IT:   raddr = it_q;
			RD_CUR:  raddr = next_rd;
			default: raddr = an_q;
		endcase
		case (ctl.uw.wa_sel)
			WA_AN:   waddr = an_q;
			WA_IT:   waddr = it_q;
			WA_P:    waddr = p_q;
			WA_N:    waddr = n_q;
			default: waddr = it_q;
		endcase
		case (ctl.uw.nd_sel)
			ND_IT:   nd = it_q;
			ND_AN:   nd = an_q;
			ND_N:    nd = n_q;
			default: nd = it_q;
		endcase
		case (ctl.uw.pd_sel)
			PD_IT:   pd = it_q;
			PD_AN:   pd = an_q;
			PD_P:    pd = p_q;
			default: pd = it_q;
		endcase
		case (ctl.uw.rtd_sel)
			RTD_IT:  rtd = it_q;
			RTD_RT:  rtd = rt_q;
			default: rtd = it_q;
		endcase
	end

	// link stores
	iclm_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_next (
		.clk(clk), .we(ctl.uw.we_next), .waddr(waddr), .wdata(nd),
		.raddr(raddr), .rdata(next_rd)
	);

	iclm_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_prev (
		.clk(clk), .we(ctl.uw.we_prev), .waddr(waddr), .wdata(pd),
		.raddr(raddr), .rdata(prev_rd)
	);

	iclm_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_root (
		.clk(clk), .we(ctl.uw.we_root), .waddr(waddr), .wdata(rtd),
		.raddr(raddr), .rdata(root_rd)
	);

	// walk flags and result
	always_comb begin
		stat.lone     = (next_rd == it_q);
		stat.walk_end = (next_rd == an_q)
			|| ((cmd_q == CMD_LOCATE) && (next_rd == it_q))
			|| (steps_q == CW'(POOL_DEPTH));
		stat.out_free = !out_valid_q || out_ready;
		steps_w = {8'd0, steps_q};
		if (cmd_q == CMD_LOCATE) begin
			walk_res = ((next_rd == an_q) || (next_rd == it_q)) ? to_byte(next_rd)
				: to_byte(an_q);
		end else begin
			walk_res = (steps_w > (CW+8)'(255)) ? 8'hFF : steps_w[7:0];
		end
	end

	// step count and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			steps_q <= '0;
			res_q   <= '0;
		end else if (ctl.uw.br == BR_WALK) begin
			if (stat.walk_end) begin
				res_q <= walk_res;
			end else begin
				steps_q <= steps_q + CW'(1);
			end
		end
	end

	iclm_useq u_useq (
		.clk(clk), .arst_n(arst_n), .start(accept), .cmd(cmd_t'(cmd)),
		.stat(stat), .ctl(ctl)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.deliver) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.deliver) begin
			result_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;

endmodule

// ===== sv/iclm_chk.sv =====
// Port-level checker for the list manager, bound to the top level.
// Depends on indexed_circular_list_manager_unit_defines.svh.
`include "indexed_circular_list_manager_unit_defines.svh"

module iclm_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] result_value
);

	// a stalled result stays offered
	`ICLM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

	// a stalled result keeps its value
	`ICLM_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(result_value), "result changed")

	// the block is busy right after an input transfer
	`ICLM_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after transfer")

	// a new result only comes out of work in flight
	`ICLM_ASSERT_NOW(a_res_from_item, $rose(out_valid), $past(!in_ready), "result without item")

endmodule

bind indexed_circular_list_manager_unit iclm_chk u_iclm_chk (.*);
